[hw/rtl/fre_pkg.sv]
// Package for the frame rate estimator: field widths, reset values of the
// configuration registers, register indexes and the rate scale constant.
// No dependencies.
`default_nettype none

package fre_pkg;

  localparam int unsigned DELTA_W    = 24;
  localparam int unsigned FPS_W      = 20;
  localparam int unsigned STAMP_W    = 63;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam int unsigned WINDOW_DEF = 16;

  localparam longint unsigned FPS_SCALE = 64'd100000000;
  localparam logic [FPS_W-1:0] FPS_MAX  = 20'hFFFFF;

  localparam logic [DELTA_W-1:0] MIN_DELTA_RST = 24'd10000;
  localparam logic [DELTA_W-1:0] MAX_DELTA_RST = 24'd10000000;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/frame_rate_estimator.sv]
// Frame rate estimator top level: timestamp ring, delta averaging and a
// restoring divider that turns the average into frames per second x100.
// Depends on fre_pkg.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  s_axis   | in        | tvalid / tready       | tuser: command, stamp_valid
//           |           |                       | tdata: stamp
//  m_axis   | out       | tvalid / tready       | tdata: fps_hundredths,
//           |           |                       |        fps_changed, delta
//  cfg      | in        | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// An accepted frame passes through the difference, check, update, divider and
// finish steps; the divider retires one quotient bit per cycle. A flush goes
// straight to output, an unset or rejected frame after the difference and check.
// Reset clears all history valid flags at once; no clearing pass is needed.
// Input ready is high only in the idle state. A finished item waits in the
// output register; the next item is accepted meanwhile and stalls only in its
// last step if the output register is still full.
`default_nettype none

module frame_rate_estimator #(
  parameter int unsigned WINDOW = fre_pkg::WINDOW_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // bit 62..0: stamp
  input  wire logic [fre_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // bit 0: command, bit 1: stamp_valid
  input  wire logic [fre_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // bit 19..0: fps_hundredths, bit 20: fps_changed, bit 44..21: smoothed_delta
  output logic [fre_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [fre_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fre_pkg::DELTA_W-1:0]    cfg_data_i
);

  import fre_pkg::*;

  localparam int unsigned     PTR_W    = $clog2(WINDOW);
  localparam longint unsigned DIVIDEND = FPS_SCALE * longint'(WINDOW);
  localparam int unsigned     DIV_W    = $clog2(DIVIDEND + 64'd1);
  localparam int unsigned     CNT_W    = $clog2(DIV_W);
  localparam int unsigned     PAD_W    = OUT_DATA_W - DELTA_W - 1 - FPS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CHK,
    ST_UPD,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [PTR_W-1:0]     ptr_q;
  logic [WINDOW-1:0]    hist_vld_q;
  logic [STAMP_W-1:0]   hist_mem [WINDOW];
  logic [STAMP_W-1:0]   old_stamp_q;
  logic [STAMP_W-1:0]   now_stamp_q;
  logic                 old_set_q;
  logic                 now_set_q;
  logic [63:0]          diff_q;
  logic [DELTA_W-1:0]   avg_q;
  logic [FPS_W-1:0]     last_fps_q;
  logic                 changed_q;
  logic [DELTA_W-1:0]   rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DELTA_W-1:0]   min_q;
  logic [DELTA_W-1:0]   max_q;
  logic                 out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                 s_hs;
  logic                 cmd_flush;
  logic                 stamp_set;
  logic [DELTA_W-1:0]   diff_lo;
  logic                 diff_ok;
  logic [DELTA_W-1:0]   up_step;
  logic [DELTA_W:0]     dn_sum;
  logic [DELTA_W-1:0]   dn_step;
  logic [DELTA_W-1:0]   avg_new;
  logic [DELTA_W:0]     trial;
  logic                 trial_ge;
  logic [DELTA_W:0]     trial_sub;
  logic [FPS_W-1:0]     fps_sat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign cmd_flush     = s_axis_tuser[0];
  assign stamp_set     = s_axis_tuser[1];
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // window difference check
  assign diff_lo = diff_q[DELTA_W-1:0];
  assign diff_ok = now_set_q && old_set_q && (diff_q[63:DELTA_W] == '0) &&
                   (diff_lo > min_q) && (diff_lo < max_q);

  // 1/16 exponential average step, floor rounding on the way down
  assign up_step = (diff_lo - avg_q) >> 4;
  assign dn_sum  = {1'b0, avg_q} - {1'b0, diff_lo} + (DELTA_W+1)'(15);
  assign dn_step = DELTA_W'(dn_sum[DELTA_W:4]);

  always_comb begin
    if (avg_q == '0) begin
      avg_new = diff_lo;
    end else if (diff_lo >= avg_q) begin
      avg_new = avg_q + up_step;
    end else begin
      avg_new = avg_q - dn_step;
    end
  end

  // restoring divider step
  assign trial     = {rem_q, quo_q[DIV_W-1]};
  assign trial_ge  = trial >= {1'b0, avg_q};
  assign trial_sub = trial - {1'b0, avg_q};

  assign fps_sat = (quo_q > DIV_W'(FPS_MAX)) ? FPS_MAX : quo_q[FPS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_DELTA_RST;
      max_q <= MAX_DELTA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_DELTA: min_q <= cfg_data_i;
        CFG_MAX_DELTA: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // history ring storage, read before write at the ring position
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      old_stamp_q <= hist_mem[ptr_q];
      now_stamp_q <= s_axis_tdata[STAMP_W-1:0];
      if (!cmd_flush) begin
        hist_mem[ptr_q] <= s_axis_tdata[STAMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ptr_q      <= '0;
      hist_vld_q <= '0;
      old_set_q  <= 1'b0;
      now_set_q  <= 1'b0;
      diff_q     <= '0;
      avg_q      <= '0;
      last_fps_q <= '0;
      changed_q  <= 1'b0;
      rem_q      <= '0;
      quo_q      <= '0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (out_vld_q && m_axis_tready && (state_q != ST_OUT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_hs) begin
            changed_q <= 1'b0;
            if (cmd_flush) begin
              hist_vld_q <= '0;
              avg_q      <= '0;
              state_q    <= ST_OUT;
            end else begin
              old_set_q         <= hist_vld_q[ptr_q];
              now_set_q         <= stamp_set;
              hist_vld_q[ptr_q] <= stamp_set;
              ptr_q   <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
              state_q <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          diff_q  <= {now_stamp_q[STAMP_W-1], now_stamp_q} -
                     {old_stamp_q[STAMP_W-1], old_stamp_q};
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          state_q <= diff_ok ? ST_UPD : ST_OUT;
        end
        ST_UPD: begin
          avg_q   <= avg_new;
          rem_q   <= '0;
          quo_q   <= DIVIDEND[DIV_W-1:0];
          cnt_q   <= CNT_W'(DIV_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= trial_ge ? trial_sub[DELTA_W-1:0] : trial[DELTA_W-1:0];
          quo_q <= {quo_q[DIV_W-2:0], trial_ge};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          changed_q  <= (fps_sat != last_fps_q);
          last_fps_q <= fps_sat;
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_vld_q || m_axis_tready) begin
            out_vld_q  <= 1'b1;
            out_data_q <= {{PAD_W{1'b0}}, avg_q, changed_q, last_fps_q};
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> avg_q != '0)
    else $error("divider running on a zero average");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs && cmd_flush |=> hist_vld_q == '0 && avg_q == '0 && state_q == ST_OUT)
    else $error("flush did not clear history and average");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> $past(state_q) == ST_DIV && $past(cnt_q) == '0)
    else $error("divider finished early");
`endif

endmodule

`default_nettype wire
